// File: rtl/aopd_pkg.sv
// ----------------------------------------------------------------------------
// aopd_pkg
// Shared types, operand kind codes and the fixed opcode pattern table of the
// AVR opcode pattern decoder.
// ----------------------------------------------------------------------------
package aopd_pkg;

   localparam int NUM_ENTRIES = 139;

   localparam int WORD_W  = 16;
   localparam int INDEX_W = 8;
   localparam int LEN_W   = 3;
   localparam int NOPS_W  = 2;
   localparam int KIND_W  = 5;

   // operand kinds
   localparam logic [KIND_W-1:0] K_NONE  = 5'd0;
   localparam logic [KIND_W-1:0] K_REG   = 5'd1;
   localparam logic [KIND_W-1:0] K_R16   = 5'd2;
   localparam logic [KIND_W-1:0] K_PAIR  = 5'd3;
   localparam logic [KIND_W-1:0] K_PAIR24 = 5'd4;
   localparam logic [KIND_W-1:0] K_DATA  = 5'd5;
   localparam logic [KIND_W-1:0] K_BIT   = 5'd6;
   localparam logic [KIND_W-1:0] K_IO    = 5'd7;
   localparam logic [KIND_W-1:0] K_BRA   = 5'd8;
   localparam logic [KIND_W-1:0] K_REL   = 5'd9;
   localparam logic [KIND_W-1:0] K_LONG  = 5'd10;
   localparam logic [KIND_W-1:0] K_DES   = 5'd11;
   localparam logic [KIND_W-1:0] K_X     = 5'd12;
   localparam logic [KIND_W-1:0] K_XP    = 5'd13;
   localparam logic [KIND_W-1:0] K_MX    = 5'd14;
   localparam logic [KIND_W-1:0] K_Y     = 5'd15;
   localparam logic [KIND_W-1:0] K_YP    = 5'd16;
   localparam logic [KIND_W-1:0] K_MY    = 5'd17;
   localparam logic [KIND_W-1:0] K_Z     = 5'd18;
   localparam logic [KIND_W-1:0] K_ZP    = 5'd19;
   localparam logic [KIND_W-1:0] K_MZ    = 5'd20;
   localparam logic [KIND_W-1:0] K_YQ    = 5'd21;
   localparam logic [KIND_W-1:0] K_ZQ    = 5'd22;

   localparam logic [LEN_W-1:0] LEN_NONE  = 3'd0;
   localparam logic [LEN_W-1:0] LEN_SHORT = 3'd2;
   localparam logic [LEN_W-1:0] LEN_LONG  = 3'd4;

   typedef struct packed {
      logic [WORD_W-1:0] fixed;
      logic [LEN_W-1:0]  len;
      logic [NOPS_W-1:0] nops;
      logic [WORD_W-1:0] mask_a;
      logic [KIND_W-1:0] kind_a;
      logic [WORD_W-1:0] mask_b;
      logic [KIND_W-1:0] kind_b;
   } entry_type;

   typedef struct packed {
      logic               hit;
      logic [INDEX_W-1:0] entry_index;
      logic [LEN_W-1:0]   length_bytes;
      logic [NOPS_W-1:0]  operand_count;
      logic [WORD_W-1:0]  first_operand_mask;
      logic [KIND_W-1:0]  first_operand_kind;
      logic [WORD_W-1:0]  second_operand_mask;
      logic [KIND_W-1:0]  second_operand_kind;
   } result_type;

   function automatic entry_type p0(logic [WORD_W-1:0] f);
      return '{f, LEN_SHORT, 2'd0, 16'h0000, K_NONE, 16'h0000, K_NONE};
   endfunction

   function automatic entry_type p1(logic [WORD_W-1:0] f, logic [LEN_W-1:0] len,
                                    logic [WORD_W-1:0] m, logic [KIND_W-1:0] k);
      return '{f, len, 2'd1, m, k, 16'h0000, K_NONE};
   endfunction

   function automatic entry_type p2(logic [WORD_W-1:0] f,
                                    logic [WORD_W-1:0] m1, logic [KIND_W-1:0] k1,
                                    logic [WORD_W-1:0] m2, logic [KIND_W-1:0] k2);
      return '{f, LEN_SHORT, 2'd2, m1, k1, m2, k2};
   endfunction

   function automatic entry_type p2l(logic [WORD_W-1:0] f,
                                     logic [WORD_W-1:0] m1, logic [KIND_W-1:0] k1,
                                     logic [WORD_W-1:0] m2, logic [KIND_W-1:0] k2);
      return '{f, LEN_LONG, 2'd2, m1, k1, m2, k2};
   endfunction

   localparam entry_type ENTRY_TABLE [NUM_ENTRIES] = '{
      p0(16'h9598), p0(16'h9488), p0(16'h94d8), p0(16'h94f8), p0(16'h94a8),
      p0(16'h94c8), p0(16'h94e8), p0(16'h94b8), p0(16'h9498), p0(16'h9519),
      p0(16'h9419), p0(16'h95d8), p0(16'h9509), p0(16'h9409), p0(16'h95c8),
      p0(16'h0000), p0(16'h9508), p0(16'h9518), p0(16'h9408), p0(16'h9458),
      p0(16'h9478), p0(16'h9428), p0(16'h9448), p0(16'h9468), p0(16'h9438),
      p0(16'h9418), p0(16'h9588), p0(16'h95e8),
      p1(16'h95f8, LEN_SHORT, 16'h0000, K_ZP),
      p0(16'h95a8),
      p1(16'h940b, LEN_SHORT, 16'h00f0, K_DES),
      p1(16'h9405, LEN_SHORT, 16'h01f0, K_REG),
      p1(16'h9488, LEN_SHORT, 16'h0070, K_BIT),
      p1(16'hf400, LEN_SHORT, 16'h03f8, K_BRA), p1(16'hf000, LEN_SHORT, 16'h03f8, K_BRA),
      p1(16'hf001, LEN_SHORT, 16'h03f8, K_BRA), p1(16'hf404, LEN_SHORT, 16'h03f8, K_BRA),
      p1(16'hf405, LEN_SHORT, 16'h03f8, K_BRA), p1(16'hf005, LEN_SHORT, 16'h03f8, K_BRA),
      p1(16'hf407, LEN_SHORT, 16'h03f8, K_BRA), p1(16'hf007, LEN_SHORT, 16'h03f8, K_BRA),
      p1(16'hf000, LEN_SHORT, 16'h03f8, K_BRA), p1(16'hf004, LEN_SHORT, 16'h03f8, K_BRA),
      p1(16'hf002, LEN_SHORT, 16'h03f8, K_BRA), p1(16'hf401, LEN_SHORT, 16'h03f8, K_BRA),
      p1(16'hf402, LEN_SHORT, 16'h03f8, K_BRA), p1(16'hf400, LEN_SHORT, 16'h03f8, K_BRA),
      p1(16'hf406, LEN_SHORT, 16'h03f8, K_BRA), p1(16'hf006, LEN_SHORT, 16'h03f8, K_BRA),
      p1(16'hf403, LEN_SHORT, 16'h03f8, K_BRA), p1(16'hf003, LEN_SHORT, 16'h03f8, K_BRA),
      p1(16'h9408, LEN_SHORT, 16'h0070, K_BIT),
      p1(16'h940e, LEN_LONG, 16'h01f1, K_LONG),
      p1(16'h9400, LEN_SHORT, 16'h01f0, K_REG), p1(16'h940a, LEN_SHORT, 16'h01f0, K_REG),
      p1(16'h9403, LEN_SHORT, 16'h01f0, K_REG),
      p1(16'h940c, LEN_LONG, 16'h01f1, K_LONG),
      p2(16'h9004, 16'h01f0, K_REG, 16'h0000, K_Z),
      p2(16'h9005, 16'h01f0, K_REG, 16'h0000, K_ZP),
      p1(16'h9406, LEN_SHORT, 16'h01f0, K_REG), p1(16'h9401, LEN_SHORT, 16'h01f0, K_REG),
      p1(16'h900f, LEN_SHORT, 16'h01f0, K_REG),
      p2(16'h9204, 16'h0000, K_Z, 16'h01f0, K_REG),
      p2(16'h9205, 16'h0000, K_Z, 16'h01f0, K_REG),
      p2(16'h9206, 16'h0000, K_Z, 16'h01f0, K_REG),
      p2(16'h9207, 16'h0000, K_Z, 16'h01f0, K_REG),
      p1(16'h920f, LEN_SHORT, 16'h01f0, K_REG),
      p1(16'hd000, LEN_SHORT, 16'h0fff, K_REL), p1(16'hc000, LEN_SHORT, 16'h0fff, K_REL),
      p1(16'h9407, LEN_SHORT, 16'h01f0, K_REG),
      p1(16'hef0f, LEN_SHORT, 16'h00f0, K_R16),
      p1(16'h9402, LEN_SHORT, 16'h01f0, K_REG),
      p2(16'h1c00, 16'h01f0, K_REG, 16'h020f, K_REG),
      p2(16'h0c00, 16'h01f0, K_REG, 16'h020f, K_REG),
      p2(16'h9600, 16'h0030, K_PAIR24, 16'h00cf, K_DATA),
      p2(16'h2000, 16'h01f0, K_REG, 16'h020f, K_REG),
      p2(16'h7000, 16'h00f0, K_R16, 16'h0f0f, K_DATA),
      p2(16'hf800, 16'h01f0, K_REG, 16'h0007, K_BIT),
      p2(16'hf400, 16'h0007, K_BIT, 16'h03f8, K_BRA),
      p2(16'hf000, 16'h0007, K_BIT, 16'h03f8, K_BRA),
      p2(16'hfa00, 16'h01f0, K_REG, 16'h0007, K_BIT),
      p2(16'h9800, 16'h00f8, K_IO, 16'h0007, K_BIT),
      p2(16'h1400, 16'h01f0, K_REG, 16'h020f, K_REG),
      p2(16'h0400, 16'h01f0, K_REG, 16'h020f, K_REG),
      p2(16'h3000, 16'h00f0, K_R16, 16'h0f0f, K_DATA),
      p2(16'h1000, 16'h01f0, K_REG, 16'h020f, K_REG),
      p2(16'h9006, 16'h01f0, K_REG, 16'h0000, K_Z),
      p2(16'h9007, 16'h01f0, K_REG, 16'h0000, K_ZP),
      p2(16'h2400, 16'h01f0, K_REG, 16'h020f, K_REG),
      p2(16'h0308, 16'h0070, K_R16, 16'h0007, K_R16),
      p2(16'h0380, 16'h0070, K_R16, 16'h0007, K_R16),
      p2(16'h0388, 16'h0070, K_R16, 16'h0007, K_R16),
      p2(16'hb000, 16'h01f0, K_REG, 16'h060f, K_DATA),
      p2(16'h900c, 16'h01f0, K_REG, 16'h0000, K_X),
      p2(16'h900d, 16'h01f0, K_REG, 16'h0000, K_XP),
      p2(16'h900e, 16'h01f0, K_REG, 16'h0000, K_MX),
      p2(16'h8008, 16'h01f0, K_REG, 16'h0000, K_Y),
      p2(16'h9009, 16'h01f0, K_REG, 16'h0000, K_YP),
      p2(16'h900a, 16'h01f0, K_REG, 16'h0000, K_MY),
      p2(16'h8000, 16'h01f0, K_REG, 16'h0000, K_Z),
      p2(16'h9001, 16'h01f0, K_REG, 16'h0000, K_ZP),
      p2(16'h9002, 16'h01f0, K_REG, 16'h0000, K_MZ),
      p2(16'h8008, 16'h01f0, K_REG, 16'h2c07, K_YQ),
      p2(16'h8000, 16'h01f0, K_REG, 16'h2c07, K_ZQ),
      p2(16'he000, 16'h00f0, K_R16, 16'h0f0f, K_DATA),
      p2l(16'h9000, 16'h01f0, K_REG, 16'h0000, K_LONG),
      p2(16'ha000, 16'h00f0, K_R16, 16'h070f, K_DATA),
      p2(16'h2c00, 16'h01f0, K_REG, 16'h020f, K_REG),
      p2(16'h0100, 16'h00f0, K_PAIR, 16'h000f, K_PAIR),
      p2(16'h9c00, 16'h01f0, K_REG, 16'h020f, K_REG),
      p2(16'h0200, 16'h00f0, K_R16, 16'h000f, K_R16),
      p2(16'h0300, 16'h0070, K_R16, 16'h0007, K_R16),
      p2(16'h2800, 16'h01f0, K_REG, 16'h020f, K_REG),
      p2(16'h6000, 16'h00f0, K_R16, 16'h0f0f, K_DATA),
      p2(16'hb800, 16'h060f, K_IO, 16'h01f0, K_REG),
      p2(16'h0800, 16'h01f0, K_REG, 16'h020f, K_REG),
      p2(16'h4000, 16'h00f0, K_R16, 16'h0f0f, K_DATA),
      p2(16'h9a00, 16'h00f8, K_IO, 16'h0007, K_BIT),
      p2(16'h9900, 16'h00f8, K_IO, 16'h0007, K_BIT),
      p2(16'h9b00, 16'h00f8, K_IO, 16'h0007, K_BIT),
      p2(16'h9700, 16'h0030, K_PAIR24, 16'h00cf, K_DATA),
      p2(16'h6000, 16'h00f0, K_R16, 16'h0f0f, K_DATA),
      p2(16'hfc00, 16'h01f0, K_REG, 16'h0007, K_BIT),
      p2(16'hfe00, 16'h01f0, K_REG, 16'h0007, K_BIT),
      p2(16'h920c, 16'h0000, K_X, 16'h01f0, K_REG),
      p2(16'h920d, 16'h0000, K_XP, 16'h01f0, K_REG),
      p2(16'h920e, 16'h0000, K_MX, 16'h01f0, K_REG),
      p2(16'h8208, 16'h0000, K_Y, 16'h01f0, K_REG),
      p2(16'h9209, 16'h0000, K_YP, 16'h01f0, K_REG),
      p2(16'h920a, 16'h0000, K_MY, 16'h01f0, K_REG),
      p2(16'h8200, 16'h0000, K_Z, 16'h01f0, K_REG),
      p2(16'h9201, 16'h0000, K_ZP, 16'h01f0, K_REG),
      p2(16'h9202, 16'h0000, K_MZ, 16'h01f0, K_REG),
      p2(16'h8208, 16'h2c07, K_YQ, 16'h01f0, K_REG),
      p2(16'h8200, 16'h2c07, K_ZQ, 16'h01f0, K_REG),
      p2l(16'h9200, 16'h0000, K_LONG, 16'h01f0, K_REG),
      p2(16'ha800, 16'h00f0, K_R16, 16'h070f, K_DATA),
      p2(16'h1800, 16'h01f0, K_REG, 16'h020f, K_REG),
      p2(16'h5000, 16'h00f0, K_R16, 16'h0f0f, K_DATA)
   };

endpackage

// File: rtl/aopd_if.sv
// ----------------------------------------------------------------------------
// aopd channel interfaces
// Valid/ready channels for opcode words in and decode results out.
// ----------------------------------------------------------------------------
interface aopd_req_if;
   logic                         valid;
   logic                         ready;
   logic [aopd_pkg::WORD_W-1:0]  opcode_word;

   modport source (output valid, output opcode_word, input ready);
   modport sink   (input valid, input opcode_word, output ready);
endinterface

interface aopd_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          hit;
   logic [aopd_pkg::INDEX_W-1:0]  entry_index;
   logic [aopd_pkg::LEN_W-1:0]    length_bytes;
   logic [aopd_pkg::NOPS_W-1:0]   operand_count;
   logic [aopd_pkg::WORD_W-1:0]   first_operand_mask;
   logic [aopd_pkg::KIND_W-1:0]   first_operand_kind;
   logic [aopd_pkg::WORD_W-1:0]   second_operand_mask;
   logic [aopd_pkg::KIND_W-1:0]   second_operand_kind;

   modport source (output valid, output hit, output entry_index, output length_bytes,
                   output operand_count, output first_operand_mask,
                   output first_operand_kind, output second_operand_mask,
                   output second_operand_kind, input ready);
   modport sink   (input valid, input hit, input entry_index, input length_bytes,
                   input operand_count, input first_operand_mask,
                   input first_operand_kind, input second_operand_mask,
                   input second_operand_kind, output ready);
endinterface

// File: rtl/aopd_match.sv
// ----------------------------------------------------------------------------
// aopd_match
// Parallel match of one opcode word against every pattern entry, with a
// priority pick of the highest matching entry index.
// ----------------------------------------------------------------------------
module aopd_match (
   input  logic [aopd_pkg::WORD_W-1:0] word,
   output aopd_pkg::result_type        result
);

   always_comb begin
      result = '0;
      // later entries override earlier ones
      for (int i = 0; i < aopd_pkg::NUM_ENTRIES; i++) begin
         if ((word & ~(aopd_pkg::ENTRY_TABLE[i].mask_a | aopd_pkg::ENTRY_TABLE[i].mask_b))
             == aopd_pkg::ENTRY_TABLE[i].fixed) begin
            result.hit                 = 1'b1;
            result.entry_index         = aopd_pkg::INDEX_W'(i);
            result.length_bytes        = aopd_pkg::ENTRY_TABLE[i].len;
            result.operand_count       = aopd_pkg::ENTRY_TABLE[i].nops;
            result.first_operand_mask  = aopd_pkg::ENTRY_TABLE[i].mask_a;
            result.first_operand_kind  = aopd_pkg::ENTRY_TABLE[i].kind_a;
            result.second_operand_mask = aopd_pkg::ENTRY_TABLE[i].mask_b;
            result.second_operand_kind = aopd_pkg::ENTRY_TABLE[i].kind_b;
         end
      end
   end

endmodule

// File: rtl/avr_opcode_pattern_decoder.sv
// ----------------------------------------------------------------------------
// avr_opcode_pattern_decoder
// Classifies one AVR instruction word per cycle while rsp is not stalled, against the
// fixed pattern table and returns the matched entry with its operand descriptors.
// ----------------------------------------------------------------------------
//   channel | dir | payload
//   req     | in  | opcode_word
//   rsp     | out | hit, entry_index, length_bytes, operand_count, operand masks/kinds
//
//   two register stages: input word register, then result register
//   rsp valid rises behind both registers; one item per cycle unless rsp stalls
//   the table match and priority pick sit between the two registers
//   reset clears both stage valid flags; no table setup needed
//   a stalled rsp holds its result; req keeps flowing while a stage is free
// ----------------------------------------------------------------------------
module avr_opcode_pattern_decoder (
   input  logic           clock,
   input  logic           reset,
   aopd_req_if.sink       req,
   aopd_rsp_if.source     rsp
);

   logic                         in_valid_ff;
   logic                         in_valid_in;
   logic [aopd_pkg::WORD_W-1:0]  in_word_ff;
   logic                         out_valid_ff;
   logic                         out_valid_in;
   aopd_pkg::result_type         out_data_ff;
   aopd_pkg::result_type         match_result;
   logic                         out_load;
   logic                         req_xfer;

   aopd_match u_match (
      .word   (in_word_ff),
      .result (match_result)
   );

   assign out_load  = !out_valid_ff || rsp.ready;
   assign req.ready = !in_valid_ff || out_load;
   assign req_xfer  = req.valid && req.ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req.ready) begin
         in_valid_in = req.valid;
      end
      out_valid_in = out_valid_ff;
      if (out_load) begin
         out_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_word_ff <= req.opcode_word;
      end
      if (out_load && in_valid_ff) begin
         out_data_ff <= match_result;
      end
   end

   assign rsp.valid               = out_valid_ff;
   assign rsp.hit                 = out_data_ff.hit;
   assign rsp.entry_index         = out_data_ff.entry_index;
   assign rsp.length_bytes        = out_data_ff.length_bytes;
   assign rsp.operand_count       = out_data_ff.operand_count;
   assign rsp.first_operand_mask  = out_data_ff.first_operand_mask;
   assign rsp.first_operand_kind  = out_data_ff.first_operand_kind;
   assign rsp.second_operand_mask = out_data_ff.second_operand_mask;
   assign rsp.second_operand_kind = out_data_ff.second_operand_kind;

   a_req_fills_stage: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> in_valid_ff)
      else $error("req transfer did not fill the input stage");

   a_stage_moves: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && out_load |=> rsp.valid)
      else $error("decoded word did not reach the result stage");

   a_hit_length: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.hit |->
         rsp.length_bytes == aopd_pkg::LEN_SHORT || rsp.length_bytes == aopd_pkg::LEN_LONG)
      else $error("hit with bad length");

   a_hit_index: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.hit |->
         rsp.entry_index <= aopd_pkg::INDEX_W'(aopd_pkg::NUM_ENTRIES - 1))
      else $error("entry index beyond table");

   a_miss_clear: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && !rsp.hit |->
         rsp.entry_index == '0 && rsp.length_bytes == aopd_pkg::LEN_NONE &&
         rsp.operand_count == '0 && rsp.first_operand_mask == '0 &&
         rsp.second_operand_mask == '0)
      else $error("miss result not cleared");

endmodule

// File: tb/sv/aopd_decode_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aopd_decode_checker
// Watches the opcode and result channels of the AVR opcode pattern decoder.
// Each opcode transfer is classified by an independent copy of the pattern
// table and queued. Each result transfer is compared field by field with the
// oldest queued decode. Mismatch and pending counts go to the testbench top.
// ----------------------------------------------------------------------------
module aopd_decode_checker
   import aopd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   aopd_req_if        req_mon,
   aopd_rsp_if        rsp_mon,
   output int         mismatch_count,
   output int         pending_count
);

   typedef struct packed {
      logic [WORD_W-1:0] fixed;
      logic [LEN_W-1:0]  len;
      logic [NOPS_W-1:0] nops;
      logic [WORD_W-1:0] m1;
      logic [KIND_W-1:0] k1;
      logic [WORD_W-1:0] m2;
      logic [KIND_W-1:0] k2;
   } decode_rule_t;

   function automatic decode_rule_t no_op(logic [WORD_W-1:0] f);
      return '{f, LEN_SHORT, 2'd0, '0, K_NONE, '0, K_NONE};
   endfunction

   function automatic decode_rule_t one_op(logic [WORD_W-1:0] f, logic [LEN_W-1:0] len,
                                           logic [WORD_W-1:0] m, logic [KIND_W-1:0] k);
      return '{f, len, 2'd1, m, k, '0, K_NONE};
   endfunction

   function automatic decode_rule_t two_op(logic [WORD_W-1:0] f,
                                           logic [WORD_W-1:0] m1, logic [KIND_W-1:0] k1,
                                           logic [WORD_W-1:0] m2, logic [KIND_W-1:0] k2);
      return '{f, LEN_SHORT, 2'd2, m1, k1, m2, k2};
   endfunction

   function automatic decode_rule_t two_op_long(logic [WORD_W-1:0] f,
                                                logic [WORD_W-1:0] m1, logic [KIND_W-1:0] k1,
                                                logic [WORD_W-1:0] m2, logic [KIND_W-1:0] k2);
      return '{f, LEN_LONG, 2'd2, m1, k1, m2, k2};
   endfunction

   localparam decode_rule_t DECODE_RULES [NUM_ENTRIES] = '{
      no_op(16'h9598), no_op(16'h9488), no_op(16'h94d8), no_op(16'h94f8),
      no_op(16'h94a8), no_op(16'h94c8), no_op(16'h94e8), no_op(16'h94b8),
      no_op(16'h9498), no_op(16'h9519), no_op(16'h9419), no_op(16'h95d8),
      no_op(16'h9509), no_op(16'h9409), no_op(16'h95c8), no_op(16'h0000),
      no_op(16'h9508), no_op(16'h9518), no_op(16'h9408), no_op(16'h9458),
      no_op(16'h9478), no_op(16'h9428), no_op(16'h9448), no_op(16'h9468),
      no_op(16'h9438), no_op(16'h9418), no_op(16'h9588), no_op(16'h95e8),
      one_op(16'h95f8, LEN_SHORT, 16'h0000, K_ZP),
      no_op(16'h95a8),
      one_op(16'h940b, LEN_SHORT, 16'h00f0, K_DES),
      one_op(16'h9405, LEN_SHORT, 16'h01f0, K_REG),
      one_op(16'h9488, LEN_SHORT, 16'h0070, K_BIT),
      one_op(16'hf400, LEN_SHORT, 16'h03f8, K_BRA),
      one_op(16'hf000, LEN_SHORT, 16'h03f8, K_BRA),
      one_op(16'hf001, LEN_SHORT, 16'h03f8, K_BRA),
      one_op(16'hf404, LEN_SHORT, 16'h03f8, K_BRA),
      one_op(16'hf405, LEN_SHORT, 16'h03f8, K_BRA),
      one_op(16'hf005, LEN_SHORT, 16'h03f8, K_BRA),
      one_op(16'hf407, LEN_SHORT, 16'h03f8, K_BRA),
      one_op(16'hf007, LEN_SHORT, 16'h03f8, K_BRA),
      one_op(16'hf000, LEN_SHORT, 16'h03f8, K_BRA),
      one_op(16'hf004, LEN_SHORT, 16'h03f8, K_BRA),
      one_op(16'hf002, LEN_SHORT, 16'h03f8, K_BRA),
      one_op(16'hf401, LEN_SHORT, 16'h03f8, K_BRA),
      one_op(16'hf402, LEN_SHORT, 16'h03f8, K_BRA),
      one_op(16'hf400, LEN_SHORT, 16'h03f8, K_BRA),
      one_op(16'hf406, LEN_SHORT, 16'h03f8, K_BRA),
      one_op(16'hf006, LEN_SHORT, 16'h03f8, K_BRA),
      one_op(16'hf403, LEN_SHORT, 16'h03f8, K_BRA),
      one_op(16'hf003, LEN_SHORT, 16'h03f8, K_BRA),
      one_op(16'h9408, LEN_SHORT, 16'h0070, K_BIT),
      one_op(16'h940e, LEN_LONG, 16'h01f1, K_LONG),
      one_op(16'h9400, LEN_SHORT, 16'h01f0, K_REG),
      one_op(16'h940a, LEN_SHORT, 16'h01f0, K_REG),
      one_op(16'h9403, LEN_SHORT, 16'h01f0, K_REG),
      one_op(16'h940c, LEN_LONG, 16'h01f1, K_LONG),
      two_op(16'h9004, 16'h01f0, K_REG, 16'h0000, K_Z),
      two_op(16'h9005, 16'h01f0, K_REG, 16'h0000, K_ZP),
      one_op(16'h9406, LEN_SHORT, 16'h01f0, K_REG),
      one_op(16'h9401, LEN_SHORT, 16'h01f0, K_REG),
      one_op(16'h900f, LEN_SHORT, 16'h01f0, K_REG),
      two_op(16'h9204, 16'h0000, K_Z, 16'h01f0, K_REG),
      two_op(16'h9205, 16'h0000, K_Z, 16'h01f0, K_REG),
      two_op(16'h9206, 16'h0000, K_Z, 16'h01f0, K_REG),
      two_op(16'h9207, 16'h0000, K_Z, 16'h01f0, K_REG),
      one_op(16'h920f, LEN_SHORT, 16'h01f0, K_REG),
      one_op(16'hd000, LEN_SHORT, 16'h0fff, K_REL),
      one_op(16'hc000, LEN_SHORT, 16'h0fff, K_REL),
      one_op(16'h9407, LEN_SHORT, 16'h01f0, K_REG),
      one_op(16'hef0f, LEN_SHORT, 16'h00f0, K_R16),
      one_op(16'h9402, LEN_SHORT, 16'h01f0, K_REG),
      two_op(16'h1c00, 16'h01f0, K_REG, 16'h020f, K_REG),
      two_op(16'h0c00, 16'h01f0, K_REG, 16'h020f, K_REG),
      two_op(16'h9600, 16'h0030, K_PAIR24, 16'h00cf, K_DATA),
      two_op(16'h2000, 16'h01f0, K_REG, 16'h020f, K_REG),
      two_op(16'h7000, 16'h00f0, K_R16, 16'h0f0f, K_DATA),
      two_op(16'hf800, 16'h01f0, K_REG, 16'h0007, K_BIT),
      two_op(16'hf400, 16'h0007, K_BIT, 16'h03f8, K_BRA),
      two_op(16'hf000, 16'h0007, K_BIT, 16'h03f8, K_BRA),
      two_op(16'hfa00, 16'h01f0, K_REG, 16'h0007, K_BIT),
      two_op(16'h9800, 16'h00f8, K_IO, 16'h0007, K_BIT),
      two_op(16'h1400, 16'h01f0, K_REG, 16'h020f, K_REG),
      two_op(16'h0400, 16'h01f0, K_REG, 16'h020f, K_REG),
      two_op(16'h3000, 16'h00f0, K_R16, 16'h0f0f, K_DATA),
      two_op(16'h1000, 16'h01f0, K_REG, 16'h020f, K_REG),
      two_op(16'h9006, 16'h01f0, K_REG, 16'h0000, K_Z),
      two_op(16'h9007, 16'h01f0, K_REG, 16'h0000, K_ZP),
      two_op(16'h2400, 16'h01f0, K_REG, 16'h020f, K_REG),
      two_op(16'h0308, 16'h0070, K_R16, 16'h0007, K_R16),
      two_op(16'h0380, 16'h0070, K_R16, 16'h0007, K_R16),
      two_op(16'h0388, 16'h0070, K_R16, 16'h0007, K_R16),
      two_op(16'hb000, 16'h01f0, K_REG, 16'h060f, K_DATA),
      two_op(16'h900c, 16'h01f0, K_REG, 16'h0000, K_X),
      two_op(16'h900d, 16'h01f0, K_REG, 16'h0000, K_XP),
      two_op(16'h900e, 16'h01f0, K_REG, 16'h0000, K_MX),
      two_op(16'h8008, 16'h01f0, K_REG, 16'h0000, K_Y),
      two_op(16'h9009, 16'h01f0, K_REG, 16'h0000, K_YP),
      two_op(16'h900a, 16'h01f0, K_REG, 16'h0000, K_MY),
      two_op(16'h8000, 16'h01f0, K_REG, 16'h0000, K_Z),
      two_op(16'h9001, 16'h01f0, K_REG, 16'h0000, K_ZP),
      two_op(16'h9002, 16'h01f0, K_REG, 16'h0000, K_MZ),
      two_op(16'h8008, 16'h01f0, K_REG, 16'h2c07, K_YQ),
      two_op(16'h8000, 16'h01f0, K_REG, 16'h2c07, K_ZQ),
      two_op(16'he000, 16'h00f0, K_R16, 16'h0f0f, K_DATA),
      two_op_long(16'h9000, 16'h01f0, K_REG, 16'h0000, K_LONG),
      two_op(16'ha000, 16'h00f0, K_R16, 16'h070f, K_DATA),
      two_op(16'h2c00, 16'h01f0, K_REG, 16'h020f, K_REG),
      two_op(16'h0100, 16'h00f0, K_PAIR, 16'h000f, K_PAIR),
      two_op(16'h9c00, 16'h01f0, K_REG, 16'h020f, K_REG),
      two_op(16'h0200, 16'h00f0, K_R16, 16'h000f, K_R16),
      two_op(16'h0300, 16'h0070, K_R16, 16'h0007, K_R16),
      two_op(16'h2800, 16'h01f0, K_REG, 16'h020f, K_REG),
      two_op(16'h6000, 16'h00f0, K_R16, 16'h0f0f, K_DATA),
      two_op(16'hb800, 16'h060f, K_IO, 16'h01f0, K_REG),
      two_op(16'h0800, 16'h01f0, K_REG, 16'h020f, K_REG),
      two_op(16'h4000, 16'h00f0, K_R16, 16'h0f0f, K_DATA),
      two_op(16'h9a00, 16'h00f8, K_IO, 16'h0007, K_BIT),
      two_op(16'h9900, 16'h00f8, K_IO, 16'h0007, K_BIT),
      two_op(16'h9b00, 16'h00f8, K_IO, 16'h0007, K_BIT),
      two_op(16'h9700, 16'h0030, K_PAIR24, 16'h00cf, K_DATA),
      two_op(16'h6000, 16'h00f0, K_R16, 16'h0f0f, K_DATA),
      two_op(16'hfc00, 16'h01f0, K_REG, 16'h0007, K_BIT),
      two_op(16'hfe00, 16'h01f0, K_REG, 16'h0007, K_BIT),
      two_op(16'h920c, 16'h0000, K_X, 16'h01f0, K_REG),
      two_op(16'h920d, 16'h0000, K_XP, 16'h01f0, K_REG),
      two_op(16'h920e, 16'h0000, K_MX, 16'h01f0, K_REG),
      two_op(16'h8208, 16'h0000, K_Y, 16'h01f0, K_REG),
      two_op(16'h9209, 16'h0000, K_YP, 16'h01f0, K_REG),
      two_op(16'h920a, 16'h0000, K_MY, 16'h01f0, K_REG),
      two_op(16'h8200, 16'h0000, K_Z, 16'h01f0, K_REG),
      two_op(16'h9201, 16'h0000, K_ZP, 16'h01f0, K_REG),
      two_op(16'h9202, 16'h0000, K_MZ, 16'h01f0, K_REG),
      two_op(16'h8208, 16'h2c07, K_YQ, 16'h01f0, K_REG),
      two_op(16'h8200, 16'h2c07, K_ZQ, 16'h01f0, K_REG),
      two_op_long(16'h9200, 16'h0000, K_LONG, 16'h01f0, K_REG),
      two_op(16'ha800, 16'h00f0, K_R16, 16'h070f, K_DATA),
      two_op(16'h1800, 16'h01f0, K_REG, 16'h020f, K_REG),
      two_op(16'h5000, 16'h00f0, K_R16, 16'h0f0f, K_DATA)
   };

   result_type expected_decodes [$];

   // highest entry wins; no hit leaves every field zero
   function automatic result_type decode_word(logic [WORD_W-1:0] word);
      result_type   r;
      decode_rule_t e;
      logic [WORD_W-1:0] rest;
      r = '0;
      for (int i = NUM_ENTRIES - 1; i >= 0; i--) begin
         e = DECODE_RULES[i];
         rest = word;
         if (e.nops >= 2'd1) rest = rest & ~e.m1;
         if (e.nops >= 2'd2) rest = rest & ~e.m2;
         if (rest == e.fixed) begin
            r.hit                 = 1'b1;
            r.entry_index         = INDEX_W'(i);
            r.length_bytes        = e.len;
            r.operand_count       = e.nops;
            r.first_operand_mask  = (e.nops >= 2'd1) ? e.m1 : '0;
            r.first_operand_kind  = (e.nops >= 2'd1) ? e.k1 : K_NONE;
            r.second_operand_mask = (e.nops >= 2'd2) ? e.m2 : '0;
            r.second_operand_kind = (e.nops >= 2'd2) ? e.k2 : K_NONE;
            return r;
         end
      end
      return r;
   endfunction

   function automatic int field_differs(string name, logic [WORD_W-1:0] want,
                                        logic [WORD_W-1:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         return 1;
      end
      return 0;
   endfunction

   always @(posedge clock) begin
      result_type want;
      int         errs;
      if (reset) begin
         expected_decodes.delete();
         mismatch_count <= 0;
         pending_count  <= 0;
      end else begin
         if (req_mon.valid && req_mon.ready)
            expected_decodes.push_back(decode_word(req_mon.opcode_word));
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_decodes.size() == 0) begin
               $display("%0t: result transfer with nothing expected, actual hit %0b entry %0d",
                        $time, rsp_mon.hit, rsp_mon.entry_index);
               mismatch_count <= mismatch_count + 1;
            end else begin
               want = expected_decodes.pop_front();
               errs = 0;
               errs += field_differs("hit", want.hit, rsp_mon.hit);
               errs += field_differs("entry_index", want.entry_index, rsp_mon.entry_index);
               errs += field_differs("length_bytes", want.length_bytes, rsp_mon.length_bytes);
               errs += field_differs("operand_count", want.operand_count,
                                     rsp_mon.operand_count);
               errs += field_differs("first_operand_mask", want.first_operand_mask,
                                     rsp_mon.first_operand_mask);
               errs += field_differs("first_operand_kind", want.first_operand_kind,
                                     rsp_mon.first_operand_kind);
               errs += field_differs("second_operand_mask", want.second_operand_mask,
                                     rsp_mon.second_operand_mask);
               errs += field_differs("second_operand_kind", want.second_operand_kind,
                                     rsp_mon.second_operand_kind);
               if (errs != 0) mismatch_count <= mismatch_count + 1;
            end
         end
         pending_count <= expected_decodes.size();
      end
   end

endmodule

// File: tb/sv/tb_avr_opcode_pattern_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_avr_opcode_pattern_decoder
// Drives opcode words into the AVR opcode pattern decoder: a directed set of
// corner words, then random words that are mostly valid encodings with random
// operand fields, plus raw and one-bit-corrupted words. Three phases vary the
// idle rates of both channels. The checker judges every result transfer.
// ----------------------------------------------------------------------------
module tb_avr_opcode_pattern_decoder;
   import aopd_pkg::*;

   localparam int RANDOM_PER_PHASE = 700;

   localparam logic [WORD_W-1:0] DIRECTED_WORDS [23] = '{
      16'h0000, 16'hffff, 16'h0001, 16'h9598, 16'h9488, 16'h95f8, 16'h940e,
      16'h95ff, 16'h9000, 16'h93f0, 16'hac0f, 16'h8208, 16'hf7ff, 16'h01ff,
      16'h96ff, 16'hefff, 16'hcfff, 16'h940b, 16'h9fff, 16'h5555, 16'haaaa,
      16'h8000, 16'h9c00
   };

   logic clock;
   logic reset;
   int   req_idle_pct;
   int   rsp_idle_pct;
   int   mismatch_count;
   int   pending_count;

   aopd_req_if req_bus ();
   aopd_rsp_if rsp_bus ();

   avr_opcode_pattern_decoder u_dut (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus)
   );

   aopd_decode_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_bus),
      .rsp_mon        (rsp_bus),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(negedge clock) begin
      if (reset) rsp_bus.ready <= 1'b0;
      else rsp_bus.ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
   end

   // mostly legal encodings with random operand bits, some raw or one bit off
   function automatic logic [WORD_W-1:0] random_word();
      entry_type         e;
      logic [WORD_W-1:0] operand_bits;
      logic [WORD_W-1:0] w;
      int                roll;
      roll = $urandom_range(0, 99);
      if (roll < 25) return WORD_W'($urandom);
      e = ENTRY_TABLE[$urandom_range(0, NUM_ENTRIES - 1)];
      operand_bits = '0;
      if (e.nops >= 2'd1) operand_bits = operand_bits | e.mask_a;
      if (e.nops >= 2'd2) operand_bits = operand_bits | e.mask_b;
      w = e.fixed | (WORD_W'($urandom) & operand_bits);
      if (roll < 35) w = w ^ (WORD_W'(1) << $urandom_range(0, WORD_W - 1));
      return w;
   endfunction

   // called and returns at a falling edge
   task automatic send_word(input logic [WORD_W-1:0] w);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.opcode_word <= w;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      @(negedge clock);
   endtask

   task automatic drain();
      req_bus.valid <= 1'b0;
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   initial begin
      reset               = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.opcode_word = '0;
      req_idle_pct        = 15;
      rsp_idle_pct        = 76;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (DIRECTED_WORDS[i]) send_word(DIRECTED_WORDS[i]);
      drain();
      repeat (RANDOM_PER_PHASE) send_word(random_word());
      drain();

      req_idle_pct = 76;
      rsp_idle_pct = 15;
      repeat (RANDOM_PER_PHASE) send_word(random_word());
      drain();

      req_idle_pct = 0;
      rsp_idle_pct = 0;
      repeat (RANDOM_PER_PHASE) send_word(random_word());
      drain();

      repeat (10) @(negedge clock);
      if (mismatch_count == 0) begin
         $display("PASS avr_opcode_pattern_decoder");
      end else begin
         $display("FAIL avr_opcode_pattern_decoder");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("FAIL avr_opcode_pattern_decoder");
      $finish;
   end

endmodule

// File: files.f
rtl/aopd_pkg.sv
rtl/aopd_if.sv
rtl/aopd_match.sv
rtl/avr_opcode_pattern_decoder.sv
tb/sv/aopd_decode_checker.sv
tb/sv/tb_avr_opcode_pattern_decoder.sv
